>>> rtl/wpt_pkg.sv
package wpt_pkg;

  // widths of the data path
  localparam int CoordW  = 10;
  localparam int WearW   = 16;
  localparam int ByteW   = 8;
  localparam int QW      = 17;   // unsigned q16 in [0, 1.0]
  localparam int NoiseW  = 12;   // signed q16 noise term
  localparam int HashW   = 24;   // low hash bits that reach the noise byte
  localparam int NStages = 8;

  localparam logic [WearW-1:0] SKIP_RESET = 16'd66;

  localparam logic [QW-1:0] Q_ONE = 17'd65536;
  localparam logic [15:0]   Q_HALF = 16'd32768;

  localparam logic [15:0] K_055 = 16'd36045;
  localparam logic [15:0] K_010 = 16'd6554;
  localparam logic [15:0] K_045 = 16'd29491;
  localparam logic [15:0] K_005 = 16'd3277;
  localparam logic [15:0] K_030 = 16'd19661;
  localparam logic [15:0] K_003 = 16'd1966;
  localparam logic [15:0] K_006 = 16'd3932;
  localparam logic [15:0] K_08  = 16'd52429;
  localparam logic [15:0] K_06  = 16'd39322;

  localparam logic [12:0] HASH_MUL_X = 13'd7919;
  localparam logic [16:0] HASH_MUL_Z = 17'd104729;
  localparam logic [HashW-1:0] HASH_MUL = 24'h5d9f3b;  // low bits of 0x45d9f3b

  // ceil(2^19 / 3), exact floor division for sums below 2^19
  localparam logic [17:0] RECIP3 = 18'd174763;
  localparam int          RECIP3_SH = 19;

  typedef logic [QW-1:0] byte_q_tab_t [256];

  // round(c * 65536 / 255), halves up
  function automatic byte_q_tab_t make_byte_q();
    byte_q_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = QW'((i * 131072 + 255) / 510);
    end
    return tab;
  endfunction

  localparam byte_q_tab_t BYTE_Q = make_byte_q();

  typedef struct packed {
    logic             skip;
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] g;
    logic [ByteW-1:0] b;
  } side_t;

endpackage

>>> rtl/wpt_coord_hash.sv
module wpt_coord_hash (
  input  logic                       clk_i,
  input  logic [wpt_pkg::CoordW-1:0] x_i,
  input  logic [wpt_pkg::CoordW-1:0] z_i,
  output logic [wpt_pkg::ByteW-1:0]  hash_byte_o
);
  import wpt_pkg::*;

  logic [27:0]      h0;
  logic [27:0]      h1;
  logic [HashW-1:0] h1_q;
  logic [HashW-1:0] h2_d;
  logic [HashW-1:0] h2_q;

  // sum stays below 2^28, so the 32-bit wrap never happens
  assign h0 = 28'(28'(x_i) * 28'(HASH_MUL_X)) + 28'(28'(z_i) * 28'(HASH_MUL_Z));
  assign h1 = h0 ^ (h0 >> 16);

  // only the low 24 bits of the product feed the final byte
  assign h2_d = HashW'(h1_q * HASH_MUL);

  always_ff @(posedge clk_i) begin
    h1_q <= h1[HashW-1:0];
    h2_q <= h2_d;
  end

  assign hash_byte_o = h2_q[7:0] ^ h2_q[23:16];

endmodule

>>> rtl/wpt_shade.sv
module wpt_shade (
  input  logic                      clk_i,
  input  logic [wpt_pkg::QW-1:0]    orig_i,
  input  logic [wpt_pkg::QW-1:0]    worn_i,
  input  logic [15:0]               blend_i,
  input  logic [wpt_pkg::QW-1:0]    darken_i,
  output logic [wpt_pkg::ByteW-1:0] byte_o,
  output logic [17:0]               mix_o
);
  import wpt_pkg::*;

  logic [QW-1:0] inv;
  logic [33:0]   pa;
  logic [33:0]   pb;
  logic [QW-1:0] qa_q;
  logic [QW-1:0] qb_q;
  logic [QW-1:0] dk_q;
  logic [17:0]   mix;
  logic [34:0]   prod_d;
  logic [34:0]   prod_q;
  logic [35:0]   rnd;
  logic [19:0]   v;
  logic [QW-1:0] vc;
  logic [24:0]   scaled;
  logic [ByteW-1:0] byte_q;

  // first stage: the two blend products
  assign inv = Q_ONE - QW'(blend_i);
  assign pa  = 34'(34'(orig_i) * 34'(inv)) + 34'(Q_HALF);
  assign pb  = 34'(34'(worn_i) * 34'(blend_i)) + 34'(Q_HALF);

  // second stage: mix times darken
  assign mix    = 18'(qa_q) + 18'(qb_q);
  assign prod_d = 35'(mix) * 35'(dk_q);

  // third stage: round, clamp, scale to a byte
  assign rnd    = 36'(prod_q) + 36'(Q_HALF);
  assign v      = rnd[35:16];
  assign vc     = (v > 20'(Q_ONE)) ? Q_ONE : v[QW-1:0];
  assign scaled = {vc, 8'b0} - 25'(vc);

  always_ff @(posedge clk_i) begin
    qa_q   <= pa[32:16];
    qb_q   <= pb[32:16];
    dk_q   <= darken_i;
    prod_q <= prod_d;
    byte_q <= scaled[23:16];
  end

  assign byte_o = byte_q;
  assign mix_o  = mix;

endmodule

>>> rtl/wear_pixel_tint.sv
// channel   direction  signals
// request   in         start_i, busy_o, pixel_x_i, pixel_z_i, wear_level_i, orig_*_i
// result    out        done_o, write_pixel_o, out_red_o, out_green_o, out_blue_o
// config    in         skip_threshold_we_i, skip_threshold_i
//
// one request per cycle, each result comes out of the eight-stage arithmetic
// pipeline after its request; busy_o stays low
// reset clears the stage valid bits and loads the threshold with 66
// results are strobed for one cycle on done_o; the receiver cannot stall
module wear_pixel_tint (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [wpt_pkg::CoordW-1:0] pixel_x_i,
  input  logic [wpt_pkg::CoordW-1:0] pixel_z_i,
  input  logic [wpt_pkg::WearW-1:0]  wear_level_i,
  input  logic [wpt_pkg::ByteW-1:0]  orig_red_i,
  input  logic [wpt_pkg::ByteW-1:0]  orig_green_i,
  input  logic [wpt_pkg::ByteW-1:0]  orig_blue_i,
  input  logic                       skip_threshold_we_i,
  input  logic [wpt_pkg::WearW-1:0]  skip_threshold_i,
  output logic                       done_o,
  output logic                       write_pixel_o,
  output logic [wpt_pkg::ByteW-1:0]  out_red_o,
  output logic [wpt_pkg::ByteW-1:0]  out_green_o,
  output logic [wpt_pkg::ByteW-1:0]  out_blue_o
);
  import wpt_pkg::*;

  logic               accept;
  logic [WearW-1:0]   thr_q;
  logic [NStages-1:0] vld_q;
  side_t              side_d;
  side_t              side_q [NStages];

  // stage 1
  logic [QW-1:0]    or1_q, og1_q, ob1_q;
  logic [WearW-1:0] t1_q;
  // stage 2
  logic [QW-1:0]    or2_q, og2_q, ob2_q;
  logic [17:0]      sum2_q;
  logic [15:0]      blend2_q;
  logic [QW-1:0]    dark2_q;
  logic [17:0]      blend_sum;
  logic [QW-1:0]    dark_sum;
  logic [ByteW-1:0] hash_byte;
  // stage 3
  logic [QW-1:0]    or3_q, og3_q, ob3_q;
  logic [15:0]      blend3_q;
  logic [QW-1:0]    dark3_q;
  logic [QW-1:0]    avg3_q;
  logic [QW-1:0]    nf3_q;
  logic [35:0]      avg_prod;
  // stage 4
  logic [QW-1:0]    or4_q, og4_q, ob4_q;
  logic [15:0]      blend4_q;
  logic [QW-1:0]    dark4_q;
  logic [15:0]      par4_q, pag4_q, pab4_q;
  logic signed [NoiseW-1:0] noise4_q;
  logic [32:0]      par_p, pag_p, pab_p;
  logic [28:0]      nf_p;
  logic signed [12:0] noise_w;
  // stage 5
  logic [QW-1:0]    or5_q, og5_q, ob5_q;
  logic [15:0]      blend5_q;
  logic [QW-1:0]    dark5_q;
  logic [QW-1:0]    wr5_q, wg5_q, wb5_q;
  logic             nneg;
  logic [10:0]      nmag;
  logic [27:0]      ng_p, nb_p;
  logic [10:0]      ng, nb;
  logic [QW-1:0]    wr_d, wg_d, wb_d;
  // stage 8
  logic [ByteW-1:0] tr, tg, tb;
  logic [17:0]      mix_r, mix_g, mix_b;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= SKIP_RESET;
      vld_q <= '0;
    end else begin
      if (skip_threshold_we_i) begin
        thr_q <= skip_threshold_i;
      end
      vld_q <= {vld_q[NStages-2:0], accept};
    end
  end

  assign side_d = '{skip: (wear_level_i < thr_q), r: orig_red_i, g: orig_green_i,
                    b: orig_blue_i};

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < NStages; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  wpt_coord_hash u_hash (
    .clk_i       (clk_i),
    .x_i         (pixel_x_i),
    .z_i         (pixel_z_i),
    .hash_byte_o (hash_byte)
  );

  // blend = qmul(t, 0.75), darken = 1 - qmul(t, 0.25)
  assign blend_sum = 18'(3) * 18'(t1_q) + 18'd2;
  assign dark_sum  = Q_ONE - QW'((QW'(t1_q) + QW'(2)) >> 2);

  // floor(sum / 3) by reciprocal
  assign avg_prod = 36'(sum2_q) * 36'(RECIP3);

  assign par_p   = 33'(33'(avg3_q) * 33'(K_055)) + 33'(Q_HALF);
  assign pag_p   = 33'(33'(avg3_q) * 33'(K_045)) + 33'(Q_HALF);
  assign pab_p   = 33'(33'(avg3_q) * 33'(K_030)) + 33'(Q_HALF);
  assign nf_p    = 29'(29'(nf3_q) * 29'(K_006)) + 29'(Q_HALF);
  assign noise_w = $signed({1'b0, nf_p[27:16]}) - $signed(13'(K_003));

  // noise products round on the magnitude
  assign nneg = noise4_q[NoiseW-1];
  assign nmag = nneg ? 11'(-noise4_q) : noise4_q[10:0];
  assign ng_p = 28'(28'(nmag) * 28'(K_08)) + 28'(Q_HALF);
  assign nb_p = 28'(28'(nmag) * 28'(K_06)) + 28'(Q_HALF);
  assign ng   = ng_p[26:16];
  assign nb   = nb_p[26:16];

  // worn tint is always positive, so 17-bit wrap arithmetic is exact
  assign wr_d = QW'(par4_q) + QW'(K_010) + {{(QW-NoiseW){noise4_q[NoiseW-1]}}, noise4_q};
  assign wg_d = nneg ? QW'(pag4_q) + QW'(K_005) - QW'(ng)
                     : QW'(pag4_q) + QW'(K_005) + QW'(ng);
  assign wb_d = nneg ? QW'(pab4_q) + QW'(K_003) - QW'(nb)
                     : QW'(pab4_q) + QW'(K_003) + QW'(nb);

  always_ff @(posedge clk_i) begin
    or1_q    <= BYTE_Q[orig_red_i];
    og1_q    <= BYTE_Q[orig_green_i];
    ob1_q    <= BYTE_Q[orig_blue_i];
    t1_q     <= wear_level_i;

    or2_q    <= or1_q;
    og2_q    <= og1_q;
    ob2_q    <= ob1_q;
    sum2_q   <= 18'(or1_q) + 18'(og1_q) + 18'(ob1_q);
    blend2_q <= blend_sum[17:2];
    dark2_q  <= dark_sum;

    or3_q    <= or2_q;
    og3_q    <= og2_q;
    ob3_q    <= ob2_q;
    blend3_q <= blend2_q;
    dark3_q  <= dark2_q;
    avg3_q   <= avg_prod[RECIP3_SH+QW-1:RECIP3_SH];
    nf3_q    <= BYTE_Q[hash_byte];

    or4_q    <= or3_q;
    og4_q    <= og3_q;
    ob4_q    <= ob3_q;
    blend4_q <= blend3_q;
    dark4_q  <= dark3_q;
    par4_q   <= par_p[31:16];
    pag4_q   <= pag_p[31:16];
    pab4_q   <= pab_p[31:16];
    noise4_q <= noise_w[NoiseW-1:0];

    or5_q    <= or4_q;
    og5_q    <= og4_q;
    ob5_q    <= ob4_q;
    blend5_q <= blend4_q;
    dark5_q  <= dark4_q;
    wr5_q    <= wr_d;
    wg5_q    <= wg_d;
    wb5_q    <= wb_d;
  end

  wpt_shade u_shade_r (
    .clk_i    (clk_i),
    .orig_i   (or5_q),
    .worn_i   (wr5_q),
    .blend_i  (blend5_q),
    .darken_i (dark5_q),
    .byte_o   (tr),
    .mix_o    (mix_r)
  );

  wpt_shade u_shade_g (
    .clk_i    (clk_i),
    .orig_i   (og5_q),
    .worn_i   (wg5_q),
    .blend_i  (blend5_q),
    .darken_i (dark5_q),
    .byte_o   (tg),
    .mix_o    (mix_g)
  );

  wpt_shade u_shade_b (
    .clk_i    (clk_i),
    .orig_i   (ob5_q),
    .worn_i   (wb5_q),
    .blend_i  (blend5_q),
    .darken_i (dark5_q),
    .byte_o   (tb),
    .mix_o    (mix_b)
  );

  assign done_o        = vld_q[NStages-1];
  assign write_pixel_o = !side_q[NStages-1].skip;
  assign out_red_o     = side_q[NStages-1].skip ? side_q[NStages-1].r : tr;
  assign out_green_o   = side_q[NStages-1].skip ? side_q[NStages-1].g : tg;
  assign out_blue_o    = side_q[NStages-1].skip ? side_q[NStages-1].b : tb;

  // every request that enters stage one leaves as a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##7 done_o)
    else $error("request did not reach the result strobe");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[0], 7))
    else $error("result strobe with no request behind it");

  a_noise_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (noise4_q >= -12'sd1966) && (noise4_q <= 12'sd1966))
    else $error("noise term out of range");

  a_darken_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (dark5_q >= 17'd49152) && (dark5_q <= Q_ONE) && (blend5_q <= 16'd49151))
    else $error("blend or darken factor out of range");

  a_mix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (mix_r <= 18'd65537) && (mix_g <= 18'd65537) && (mix_b <= 18'd65537))
    else $error("blended channel above one");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wpt_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] z;
    logic [WearW-1:0]  wear;
    logic [ByteW-1:0]  r;
    logic [ByteW-1:0]  g;
    logic [ByteW-1:0]  b;
  } texel_t;

  typedef struct packed {
    logic             write;
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] g;
    logic [ByteW-1:0] b;
  } tint_t;

  typedef struct packed {
    texel_t px;
    logic   typed;
    tint_t  res;
  } tint_case_t;

  // q16 constants of the tint math
  localparam longint QONE   = 65536;
  localparam longint C_055  = 36045;
  localparam longint C_010  = 6554;
  localparam longint C_045  = 29491;
  localparam longint C_005  = 3277;
  localparam longint C_030  = 19661;
  localparam longint C_003  = 1966;
  localparam longint C_006  = 3932;
  localparam longint C_08   = 52429;
  localparam longint C_06   = 39322;
  localparam longint C_075  = 49152;
  localparam longint C_025  = 16384;

  localparam logic [WearW-1:0] THR_AFTER_RESET = 16'd66;
  localparam int QUIET_LIMIT = 300;
  localparam int DRAIN_CYCLES = 16;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CoordW-1:0]   pixel_x_i;
  logic [CoordW-1:0]   pixel_z_i;
  logic [WearW-1:0]    wear_level_i;
  logic [ByteW-1:0]    orig_red_i;
  logic [ByteW-1:0]    orig_green_i;
  logic [ByteW-1:0]    orig_blue_i;
  logic                skip_threshold_we_i;
  logic [WearW-1:0]    skip_threshold_i;
  logic                done_o;
  logic                write_pixel_o;
  logic [ByteW-1:0]    out_red_o;
  logic [ByteW-1:0]    out_green_o;
  logic [ByteW-1:0]    out_blue_o;

  // side band that travels with a request from the table
  logic  row_typed;
  tint_t row_tint;

  tint_t       tint_due [$];
  tint_t       got_tint;
  tint_t       want_tint;
  logic [WearW-1:0] thr_model;
  logic [WearW-1:0] cur_thr;
  bit          gaps_on;
  int          fail_count;
  int          quiet_cycles;
  int          n_req;
  int          n_written;
  int          n_checked;
  int          n_thr;

  tint_case_t tint_cases [18] = '{
    // below the reset threshold, bytes pass through
    {10'd0,    10'd0,    16'd0,     8'h12, 8'h34, 8'h56, 1'b1, 1'b0, 8'h12, 8'h34, 8'h56},
    {10'd1023, 10'd1023, 16'd65,    8'hff, 8'h00, 8'hff, 1'b1, 1'b0, 8'hff, 8'h00, 8'hff},
    {10'd1023, 10'd1023, 16'd0,     8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'hff, 8'hff, 8'hff},
    {10'd0,    10'd1023, 16'd65,    8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
    // at the threshold and full wear
    {10'd0,    10'd0,    16'd66,    8'h00, 8'h00, 8'h00, 1'b0, 25'd0},
    {10'd0,    10'd0,    16'd65535, 8'h00, 8'h00, 8'h00, 1'b0, 25'd0},
    {10'd1023, 10'd1023, 16'd65535, 8'hff, 8'hff, 8'hff, 1'b0, 25'd0},
    {10'd1023, 10'd0,    16'd65535, 8'hff, 8'h00, 8'h00, 1'b0, 25'd0},
    {10'd0,    10'd1023, 16'd65535, 8'h00, 8'hff, 8'h00, 1'b0, 25'd0},
    {10'd341,  10'd682,  16'd65535, 8'h00, 8'h00, 8'hff, 1'b0, 25'd0},
    {10'd1023, 10'd0,    16'd65535, 8'h00, 8'h00, 8'h00, 1'b0, 25'd0},
    // mid wear and alternating bit patterns
    {10'd512,  10'd512,  16'd32768, 8'h80, 8'h80, 8'h80, 1'b0, 25'd0},
    {10'd1,    10'd0,    16'd67,    8'hff, 8'hff, 8'hff, 1'b0, 25'd0},
    {10'd0,    10'd1,    16'd1000,  8'h01, 8'hfe, 8'h7f, 1'b0, 25'd0},
    {10'h2aa,  10'h155,  16'hc000,  8'haa, 8'h55, 8'haa, 1'b0, 25'd0},
    {10'h155,  10'h2aa,  16'h3fff,  8'h55, 8'haa, 8'h55, 1'b0, 25'd0},
    {10'd7,    10'd9,    16'd60000, 8'hc8, 8'h10, 8'h40, 1'b0, 25'd0},
    {10'd100,  10'd200,  16'd66,    8'hff, 8'h00, 8'h80, 1'b0, 25'd0}
  };

  wear_pixel_tint dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .pixel_x_i           (pixel_x_i),
    .pixel_z_i           (pixel_z_i),
    .wear_level_i        (wear_level_i),
    .orig_red_i          (orig_red_i),
    .orig_green_i        (orig_green_i),
    .orig_blue_i         (orig_blue_i),
    .skip_threshold_we_i (skip_threshold_we_i),
    .skip_threshold_i    (skip_threshold_i),
    .done_o              (done_o),
    .write_pixel_o       (write_pixel_o),
    .out_red_o           (out_red_o),
    .out_green_o         (out_green_o),
    .out_blue_o          (out_blue_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // q16 product, rounded to nearest with halves away from zero
  function automatic longint q_mul(longint a, longint b);
    longint ua;
    longint ub;
    longint p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = (ua * ub + 32768) >>> 16;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint byte_to_q16(logic [7:0] c);
    return (longint'(c) * 131072 + 255) / 510;
  endfunction

  function automatic logic [7:0] q16_to_byte(longint v);
    longint c;
    c = (v < 0) ? 0 : ((v > QONE) ? QONE : v);
    return 8'((c * 255) >>> 16);
  endfunction

  function automatic logic [31:0] texel_hash(logic [9:0] x, logic [9:0] z);
    logic [31:0] h;
    h = 32'(x) * 32'd7919 + 32'(z) * 32'd104729;
    h = h ^ (h >> 16);
    h = h * 32'h045d9f3b;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic tint_t tint_texel(texel_t p, logic [WearW-1:0] thr);
    tint_t      res;
    logic [31:0] h;
    longint     orig_q [3];
    longint     worn_q [3];
    longint     avg;
    longint     noise;
    longint     blend;
    longint     darken;
    longint     mix;
    logic [7:0] px_bytes [3];
    if (p.wear < thr) begin
      return {1'b0, p.r, p.g, p.b};
    end
    px_bytes[0] = p.r;
    px_bytes[1] = p.g;
    px_bytes[2] = p.b;
    for (int c = 0; c < 3; c++) begin
      orig_q[c] = byte_to_q16(px_bytes[c]);
    end
    avg = (orig_q[0] + orig_q[1] + orig_q[2]) / 3;
    h = texel_hash(p.x, p.z);
    noise = q_mul(byte_to_q16(h[7:0]), C_006) - C_003;
    worn_q[0] = q_mul(avg, C_055) + C_010 + noise;
    worn_q[1] = q_mul(avg, C_045) + C_005 + q_mul(noise, C_08);
    worn_q[2] = q_mul(avg, C_030) + C_003 + q_mul(noise, C_06);
    blend = q_mul(longint'(p.wear), C_075);
    darken = QONE - q_mul(longint'(p.wear), C_025);
    for (int c = 0; c < 3; c++) begin
      mix = q_mul(orig_q[c], QONE - blend) + q_mul(worn_q[c], blend);
      px_bytes[c] = q16_to_byte(q_mul(mix, darken));
    end
    res.write = 1'b1;
    res.r = px_bytes[0];
    res.g = px_bytes[1];
    res.b = px_bytes[2];
    return res;
  endfunction

  function automatic logic [WearW-1:0] rand_wear(logic [WearW-1:0] thr);
    int w;
    case ($urandom_range(0, 9))
      0, 1: begin
        // around the threshold, both sides
        w = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (w < 0) w = 0;
        if (w > 65535) w = 65535;
      end
      2: w = 0;
      3: w = 65535;
      4: w = $urandom_range(65000, 65535);
      default: w = $urandom_range(0, 65535);
    endcase
    return 16'(w);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [9:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // called in the time step of a rising edge; returns at the accepting edge
  task automatic send_texel(texel_t p, logic typed, tint_t res);
    while (gaps_on && $urandom_range(0, 99) < 36) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    pixel_x_i    <= p.x;
    pixel_z_i    <= p.z;
    wear_level_i <= p.wear;
    orig_red_i   <= p.r;
    orig_green_i <= p.g;
    orig_blue_i  <= p.b;
    row_typed    <= typed;
    row_tint     <= res;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    texel_t p;
    for (int i = 0; i < n; i++) begin
      p.x = rand_coord();
      p.z = rand_coord();
      p.wear = rand_wear(cur_thr);
      p.r = rand_byte();
      p.g = rand_byte();
      p.b = rand_byte();
      send_texel(p, 1'b0, '0);
    end
  endtask

  task automatic drain_requests();
    start_i <= 1'b0;
    do @(posedge clk_i); while (tint_due.size() != 0);
  endtask

  task automatic set_threshold(logic [WearW-1:0] v);
    drain_requests();
    skip_threshold_we_i <= 1'b1;
    skip_threshold_i    <= v;
    cur_thr = v;
    n_thr++;
    @(posedge clk_i);
    skip_threshold_we_i <= 1'b0;
  endtask

  // request capture, result check and watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      thr_model = THR_AFTER_RESET;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (start_i && !busy_o) begin
        want_tint = row_typed ? row_tint :
                    tint_texel({pixel_x_i, pixel_z_i, wear_level_i,
                                orig_red_i, orig_green_i, orig_blue_i}, thr_model);
        tint_due.insert(tint_due.size(), want_tint);
        n_req++;
        if (want_tint.write) n_written++;
        quiet_cycles = 0;
      end
      if (skip_threshold_we_i) begin
        thr_model = skip_threshold_i;
      end
      if (done_o) begin
        quiet_cycles = 0;
        got_tint = {write_pixel_o, out_red_o, out_green_o, out_blue_o};
        if (tint_due.size() == 0) begin
          $display("%0t: result with no request pending, expected none, got %h",
                   $time, got_tint);
          fail_count++;
        end else begin
          want_tint = tint_due.pop_front();
          n_checked++;
          check_field("write_pixel", 8'(want_tint.write), 8'(got_tint.write));
          check_field("out_red", want_tint.r, got_tint.r);
          check_field("out_green", want_tint.g, got_tint.g);
          check_field("out_blue", want_tint.b, got_tint.b);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, tint_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    pixel_x_i = '0;
    pixel_z_i = '0;
    wear_level_i = '0;
    orig_red_i = '0;
    orig_green_i = '0;
    orig_blue_i = '0;
    skip_threshold_we_i = 1'b0;
    skip_threshold_i = '0;
    row_typed = 1'b0;
    row_tint = '0;
    gaps_on = 1'b1;
    fail_count = 0;
    n_req = 0;
    n_written = 0;
    n_checked = 0;
    n_thr = 1;
    cur_thr = THR_AFTER_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tint_cases[i]) begin
      send_texel(tint_cases[i].px, tint_cases[i].typed, tint_cases[i].res);
    end
    run_random(200);

    // every texel written
    set_threshold(16'd0);
    run_random(150);

    // only full wear gets written
    set_threshold(16'hffff);
    run_random(100);

    // back-to-back requests, no gaps
    gaps_on = 1'b0;
    set_threshold(16'($urandom_range(1, 65534)));
    run_random(150);

    gaps_on = 1'b1;
    set_threshold(16'd1);
    run_random(150);

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d texel requests (%0d tinted, %0d passed through), %0d checked",
             n_req, n_written, n_req - n_written, n_checked);
    $display("over %0d threshold settings including 0 and 65535, %0d mismatches",
             n_thr, fail_count);
    if (fail_count == 0 && tint_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
